// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the controller rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/dqwps_pkg.sv =====
// shared types, codes and constants of the two-queue priority server
package dqwps_pkg;

    // default sizes
    localparam int DEPTH_DEF    = 32;
    localparam int ID_WIDTH_DEF = 16;

    // configuration register widths and reset values
    localparam int          QL_W      = 6;
    localparam int          BURST_W   = 4;
    localparam logic [5:0]  QLIMIT_RST = 6'd30;
    localparam logic [3:0]  BURST_RST  = 4'd3;
    localparam logic [3:0]  RUN_MAX    = 4'd15;

    // register indexes on the configuration port
    localparam logic REG_QUEUE_LIMIT    = 1'b0;
    localparam logic REG_PRIORITY_BURST = 1'b1;

    // request kinds
    localparam logic [1:0] KIND_ENQ_PRIO = 2'd0;
    localparam logic [1:0] KIND_ENQ_GEN  = 2'd1;
    localparam logic [1:0] KIND_SERVE    = 2'd2;

    // result status codes
    localparam logic [1:0] ST_ENQUEUED = 2'd0;
    localparam logic [1:0] ST_DROPPED  = 2'd1;
    localparam logic [1:0] ST_SERVED   = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    // queue select
    localparam logic Q_PRIO = 1'b0;
    localparam logic Q_GEN  = 1'b1;

    // controller states
    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    // entry memory strobes
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

endpackage

// ===== rtl/core/dqwps_store.sv =====
// entry memory holding both queues, one port, registered read data
module dqwps_store #(
    parameter int DEPTH    = dqwps_pkg::DEPTH_DEF,
    parameter int ID_WIDTH = dqwps_pkg::ID_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  dqwps_pkg::t_mem_ctl               i_ctl,
    input  logic [$clog2(DEPTH):0]            i_addr,
    input  logic [ID_WIDTH-1:0]               i_wdata,
    output logic [ID_WIDTH-1:0]               o_rdata
);
    import dqwps_pkg::*;

    localparam int ADDR_W    = $clog2(DEPTH) + 1;
    localparam int MEM_DEPTH = 2 ** ADDR_W;

    logic [ID_WIDTH-1:0] r_mem [MEM_DEPTH];
    logic [ID_WIDTH-1:0] r_rdata;

    // upper address bit selects the queue, contents left undefined at reset
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/dqwps_ctrl.sv =====
// queue pointers, serve arbitration, sequencer and result register
`include "assert_macros.svh"

module dqwps_ctrl #(
    parameter int DEPTH    = dqwps_pkg::DEPTH_DEF,
    parameter int ID_WIDTH = dqwps_pkg::ID_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [1:0]                        i_kind,
    input  logic [ID_WIDTH-1:0]               i_customer_id,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [1:0]                        o_status,
    output logic [ID_WIDTH-1:0]               o_served_id,
    output logic                              o_from_priority,
    input  logic [dqwps_pkg::QL_W-1:0]        i_queue_limit,
    input  logic [dqwps_pkg::BURST_W-1:0]     i_priority_burst,
    output dqwps_pkg::t_mem_ctl               o_mem_ctl,
    output logic [$clog2(DEPTH):0]            o_mem_addr,
    output logic [ID_WIDTH-1:0]               o_mem_wdata,
    input  logic [ID_WIDTH-1:0]               i_mem_rdata
);
    import dqwps_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > QL_W) ? CNT_W : QL_W;

    t_state               r_state;
    t_state               n_state;
    logic [IDX_W-1:0]     r_head [2];
    logic [IDX_W-1:0]     r_tail [2];
    logic [CNT_W-1:0]     r_fill [2];
    logic [BURST_W-1:0]   r_run;
    logic                 r_out_valid;
    logic [1:0]           r_status;
    logic [ID_WIDTH-1:0]  r_served;
    logic                 r_fromp;

    logic [CMP_W-1:0]     ql_ext;
    logic [CMP_W-1:0]     lim_cmp;
    logic [CNT_W-1:0]     lim;
    logic                 empty_p;
    logic                 empty_g;
    logic                 accept;
    logic                 push;
    logic                 pop;
    logic                 sel_q;
    logic [1:0]           status;
    logic                 fromp;
    logic                 load_rd;
    t_mem_ctl             mem_ctl;

    // next index, wrapping at the effective limit
    function automatic logic [IDX_W-1:0] f_advance(input logic [IDX_W-1:0] idx,
                                                   input logic [CNT_W-1:0] limit);
        logic [CNT_W-1:0] nx;
        nx = CNT_W'(idx) + CNT_W'(1);
        return (nx >= limit) ? '0 : nx[IDX_W-1:0];
    endfunction

    // effective limit clamped to one through depth
    always_comb begin
        ql_ext = CMP_W'(i_queue_limit);
        if (ql_ext == '0) begin
            lim_cmp = CMP_W'(1);
        end else if (ql_ext > CMP_W'(DEPTH)) begin
            lim_cmp = CMP_W'(DEPTH);
        end else begin
            lim_cmp = ql_ext;
        end
        lim = lim_cmp[CNT_W-1:0];
    end

    assign empty_p = (r_fill[Q_PRIO] == '0);
    assign empty_g = (r_fill[Q_GEN] == '0);
    assign accept  = i_in_valid && o_in_ready;

    // request decode and serve arbitration
    always_comb begin
        push   = 1'b0;
        pop    = 1'b0;
        sel_q  = Q_PRIO;
        status = ST_DROPPED;
        fromp  = 1'b0;
        unique case (i_kind)
            KIND_ENQ_PRIO, KIND_ENQ_GEN: begin
                sel_q = i_kind[0];
                if (r_fill[i_kind[0]] < lim) begin
                    push   = 1'b1;
                    status = ST_ENQUEUED;
                end
            end
            KIND_SERVE: begin
                priority if (!empty_p && (r_run < i_priority_burst)) begin
                    pop    = 1'b1;
                    sel_q  = Q_PRIO;
                    fromp  = 1'b1;
                    status = ST_SERVED;
                end else if (!empty_g) begin
                    pop    = 1'b1;
                    sel_q  = Q_GEN;
                    status = ST_SERVED;
                end else if (!empty_p) begin
                    pop    = 1'b1;
                    sel_q  = Q_PRIO;
                    fromp  = 1'b1;
                    status = ST_SERVED;
                end else begin
                    status = ST_EMPTY;
                end
            end
            default: begin
                status = ST_DROPPED;
            end
        endcase
    end

    // memory access, at most one per accepted item
    assign mem_ctl.wr_en = accept && push;
    assign mem_ctl.rd_en = accept && pop;
    assign o_mem_ctl     = mem_ctl;
    assign o_mem_addr    = {sel_q, (pop ? r_head[sel_q] : r_tail[sel_q])};
    assign o_mem_wdata   = i_customer_id;

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && pop) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_in_ready = 1'b0;
        load_rd    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = !r_out_valid || i_out_ready;
            end
            S_READ: begin
                load_rd = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // pointers, counts, run counter and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head[0]   <= '0;
            r_head[1]   <= '0;
            r_tail[0]   <= '0;
            r_tail[1]   <= '0;
            r_fill[0]   <= '0;
            r_fill[1]   <= '0;
            r_run       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept && push) begin
                r_tail[sel_q] <= f_advance(r_tail[sel_q], lim);
                r_fill[sel_q] <= r_fill[sel_q] + CNT_W'(1);
            end
            if (accept && pop) begin
                r_head[sel_q] <= f_advance(r_head[sel_q], lim);
                r_fill[sel_q] <= r_fill[sel_q] - CNT_W'(1);
                if (fromp) begin
                    if (r_run < RUN_MAX) begin
                        r_run <= r_run + BURST_W'(1);
                    end
                end else begin
                    r_run <= '0;
                end
            end
            if (accept) begin
                r_out_valid <= !pop;
            end else if (load_rd) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= status;
            r_fromp  <= fromp;
            r_served <= '0;
        end else if (load_rd) begin
            r_served <= i_mem_rdata;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_served_id     = r_served;
    assign o_from_priority = r_fromp;

    // checks
    `ASSERT_IMPLY(a_read_blocks, i_clk, i_rst_n, r_state == S_READ, !o_in_ready && !r_out_valid, "input taken or result shown while entry read pending")
    `ASSERT_NEXT(a_serve_reads, i_clk, i_rst_n, mem_ctl.rd_en, r_state == S_READ && r_status == ST_SERVED, "serve read not followed by result load")
    `ASSERT_NEXT(a_enq_result, i_clk, i_rst_n, mem_ctl.wr_en, r_out_valid && r_status == ST_ENQUEUED && !r_fromp, "enqueue write without enqueued result")
    `ASSERT_IMPLY(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill[0] <= CNT_W'(DEPTH) && r_fill[1] <= CNT_W'(DEPTH), "queue fill count above depth")

endmodule

// ===== rtl/core/dual_queue_weighted_priority_server.sv =====
// top level: configuration registers, controller and entry memory
// results: an enqueue, drop or nothing-to-serve result is valid in the cycle after the item is
//   taken, a served entry after the entry memory read register and then the result register
// throughput: 1 item per cycle, given the result is taken as soon as it is shown; an item that
//   serves an entry holds off the next item until its memory read has loaded the result register
// reset: synchronous active low; clears pointers, fill counts, run count and result
//   valid, loads queue_limit 30 and priority_burst 3; entry memory is not cleared
module dual_queue_weighted_priority_server #(
    parameter int DEPTH    = dqwps_pkg::DEPTH_DEF,
    parameter int ID_WIDTH = dqwps_pkg::ID_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_kind,
    input  logic [ID_WIDTH-1:0]  i_customer_id,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [1:0]           o_status,
    output logic [ID_WIDTH-1:0]  o_served_id,
    output logic                 o_from_priority,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import dqwps_pkg::*;

    logic [QL_W-1:0]       r_queue_limit;
    logic [BURST_W-1:0]    r_priority_burst;
    logic                  cfg_wr;
    t_mem_ctl              mem_ctl;
    logic [$clog2(DEPTH):0] mem_addr;
    logic [ID_WIDTH-1:0]   mem_wdata;
    logic [ID_WIDTH-1:0]   mem_rdata;

    // register write on the access phase
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queue_limit    <= QLIMIT_RST;
            r_priority_burst <= BURST_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_QUEUE_LIMIT:    r_queue_limit    <= pwdata[QL_W-1:0];
                REG_PRIORITY_BURST: r_priority_burst <= pwdata[BURST_W-1:0];
                default:            r_queue_limit    <= r_queue_limit;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (paddr[2])
            REG_QUEUE_LIMIT:    prdata = {{(32 - QL_W){1'b0}}, r_queue_limit};
            REG_PRIORITY_BURST: prdata = {{(32 - BURST_W){1'b0}}, r_priority_burst};
            default:            prdata = '0;
        endcase
    end

    dqwps_ctrl #(
        .DEPTH    (DEPTH),
        .ID_WIDTH (ID_WIDTH)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_kind           (i_kind),
        .i_customer_id    (i_customer_id),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_served_id      (o_served_id),
        .o_from_priority  (o_from_priority),
        .i_queue_limit    (r_queue_limit),
        .i_priority_burst (r_priority_burst),
        .o_mem_ctl        (mem_ctl),
        .o_mem_addr       (mem_addr),
        .o_mem_wdata      (mem_wdata),
        .i_mem_rdata      (mem_rdata)
    );

    dqwps_store #(
        .DEPTH    (DEPTH),
        .ID_WIDTH (ID_WIDTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

endmodule
